@@ rtl/s2i_pkg.sv @@
package s2i_pkg;

  localparam int VALUE_WIDTH = 64;
  localparam int COUNT_WIDTH = 16;
  localparam int CHAR_WIDTH  = 8;
  localparam int BASE_WIDTH  = 6;
  localparam int CFG_INDEX_WIDTH = 1;
  localparam int CFG_DATA_WIDTH  = BASE_WIDTH;

  // Product of accumulator and base, plus one bit for the digit add
  localparam int PROD_WIDTH = VALUE_WIDTH + BASE_WIDTH + 1;

  localparam logic [BASE_WIDTH-1:0] MAX_BASE   = BASE_WIDTH'(36);
  localparam logic [BASE_WIDTH-1:0] DIGIT_NONE = BASE_WIDTH'(36);
  localparam logic [BASE_WIDTH-1:0] BASE_HEX   = BASE_WIDTH'(16);
  localparam logic [BASE_WIDTH-1:0] BASE_OCT   = BASE_WIDTH'(8);
  localparam logic [BASE_WIDTH-1:0] BASE_DEC   = BASE_WIDTH'(10);
  localparam logic [BASE_WIDTH-1:0] BASE_ONE   = BASE_WIDTH'(1);
  localparam logic [BASE_WIDTH-1:0] BASE_TWO   = BASE_WIDTH'(2);
  localparam logic [BASE_WIDTH-1:0] BASE_AUTO  = BASE_WIDTH'(0);

  localparam logic [CHAR_WIDTH-1:0] CH_LOWER_X = 8'h78;
  localparam logic [CHAR_WIDTH-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_WIDTH-1:0] CH_NINE    = 8'h39;
  localparam logic [CHAR_WIDTH-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CHAR_WIDTH-1:0] CH_UPPER_Z = 8'h5A;
  localparam logic [CHAR_WIDTH-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CHAR_WIDTH-1:0] CH_LOWER_Z = 8'h7A;
  localparam logic [CHAR_WIDTH-1:0] CH_MINUS   = 8'h2D;
  localparam logic [CHAR_WIDTH-1:0] CH_PLUS    = 8'h2B;
  localparam logic [CHAR_WIDTH-1:0] CH_SPACE   = 8'h20;
  localparam logic [CHAR_WIDTH-1:0] CH_TAB     = 8'h09;
  localparam logic [CHAR_WIDTH-1:0] CH_CR      = 8'h0D;

  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_NUMBER_BASE = 1'b0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SIGNED_MODE = 1'b1;

  typedef enum logic [2:0] {
    PH_SPACE    = 3'd0,
    PH_FIRST    = 3'd1,
    PH_ZERO     = 3'd2,
    PH_HEXFIRST = 3'd3,
    PH_DIGITS   = 3'd4,
    PH_NOINT    = 3'd5,
    PH_VALUE    = 3'd6,
    PH_BADBASE  = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOINT   = 2'd1,
    ST_RANGE   = 2'd2,
    ST_BADBASE = 2'd3
  } status_t;

  typedef struct packed {
    logic [CHAR_WIDTH-1:0] char_code;
    logic                  is_last;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] value_bits;
    logic [1:0]             status_code;
    logic [COUNT_WIDTH-1:0] consumed_count;
  } out_item_t;

  // Parse state at the end of a string, handed to the finishing stage
  typedef struct packed {
    phase_t                 phase;
    logic [VALUE_WIDTH-1:0] acc;
    logic                   neg;
    logic                   ovf;
    logic                   sgn;
    logic [COUNT_WIDTH-1:0] pos;
  } s2i_raw_t;

  function automatic logic [BASE_WIDTH-1:0] digit_of(input logic [CHAR_WIDTH-1:0] c);
    logic [BASE_WIDTH-1:0] d;
    d = DIGIT_NONE;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = BASE_WIDTH'(c - CH_ZERO);
    end else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      d = BASE_WIDTH'(c - CH_UPPER_A) + BASE_DEC;
    end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
      d = BASE_WIDTH'(c - CH_LOWER_A) + BASE_DEC;
    end
    return d;
  endfunction

  function automatic logic is_space(input logic [CHAR_WIDTH-1:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

endpackage

@@ rtl/s2i_in_reg.sv @@
module s2i_in_reg
  import s2i_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  input  logic     step_go,
  output logic     item_vld,
  output in_item_t item
);

  logic     vld_r, vld_nxt;
  in_item_t item_r;

  assign in_ready = !vld_r || step_go;
  assign vld_nxt  = in_ready ? in_valid : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign item_vld = vld_r;
  assign item     = item_r;

endmodule

@@ rtl/s2i_parse.sv @@
module s2i_parse
  import s2i_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_wdata,
  input  logic                       item_vld,
  input  in_item_t                   item,
  input  logic                       raw_ready,
  output logic                       step_go,
  output logic                       raw_push,
  output s2i_raw_t                   raw
);

  logic [BASE_WIDTH-1:0]  base_r;
  logic                   sgn_r;

  phase_t                 phase_r, phase_nxt;
  logic [VALUE_WIDTH-1:0] acc_r, acc_nxt;
  logic                   neg_r, neg_nxt;
  logic [BASE_WIDTH-1:0]  ab_r, ab_nxt;
  logic [COUNT_WIDTH-1:0] pos_r, pos_nxt;
  logic                   ovf_r, ovf_nxt;

  logic [CHAR_WIDTH-1:0]  c;
  logic [BASE_WIDTH-1:0]  d;
  logic [PROD_WIDTH-1:0]  prod;
  logic                   adv, start, first, more;

  assign c    = item.char_code;
  assign d    = digit_of(c);
  // Only a last character needs room downstream
  assign step_go  = item_vld && (!item.is_last || raw_ready);
  assign raw_push = step_go && item.is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= BASE_AUTO;
      sgn_r  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NUMBER_BASE: base_r <= cfg_wdata;
        CFG_SIGNED_MODE: sgn_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    neg_nxt   = neg_r;
    ab_nxt    = ab_r;
    ovf_nxt   = ovf_r;
    adv       = 1'b0;
    start     = 1'b0;
    first     = 1'b0;
    more      = 1'b0;
    prod      = PROD_WIDTH'(acc_r) * PROD_WIDTH'(ab_r) + PROD_WIDTH'(d);

    // Latch the base at the first character of a string
    if (phase_r == PH_SPACE && pos_r == '0) begin
      ab_nxt = base_r;
      if (base_r == BASE_ONE || base_r > MAX_BASE) begin
        phase_nxt = PH_BADBASE;
      end
    end

    unique case (phase_nxt)
      PH_SPACE: begin
        if (is_space(c)) begin
          adv = 1'b1;
        end else if (!item.is_last && (c == CH_PLUS || (c == CH_MINUS && sgn_r))) begin
          neg_nxt   = (c == CH_MINUS);
          phase_nxt = PH_FIRST;
          adv       = 1'b1;
        end else begin
          start = 1'b1;
        end
      end
      PH_FIRST: start = 1'b1;
      PH_ZERO: begin
        if (c == CH_LOWER_X) begin
          ab_nxt    = BASE_HEX;
          phase_nxt = PH_HEXFIRST;
          adv       = 1'b1;
        end else begin
          ab_nxt    = BASE_OCT;
          phase_nxt = PH_DIGITS;
          more      = 1'b1;
          prod      = PROD_WIDTH'(acc_r) * PROD_WIDTH'(BASE_OCT) + PROD_WIDTH'(d);
        end
      end
      PH_HEXFIRST: first = 1'b1;
      PH_DIGITS:   more  = 1'b1;
      default: ;
    endcase

    if (start) begin
      if (ab_nxt == BASE_AUTO) begin
        if (c == CH_ZERO) begin
          acc_nxt   = '0;
          phase_nxt = PH_ZERO;
          adv       = 1'b1;
        end else begin
          ab_nxt = BASE_DEC;
          first  = 1'b1;
        end
      end else begin
        first = 1'b1;
      end
    end

    if (first) begin
      if (d >= ab_nxt || ab_nxt < BASE_TWO) begin
        phase_nxt = PH_NOINT;
      end else begin
        acc_nxt   = VALUE_WIDTH'(d);
        phase_nxt = PH_DIGITS;
        adv       = 1'b1;
      end
    end

    if (more) begin
      if (d >= ab_nxt || ab_nxt < BASE_TWO) begin
        phase_nxt = PH_VALUE;
      end else begin
        if (!ovf_r) begin
          if (|prod[PROD_WIDTH-1:VALUE_WIDTH]) begin
            acc_nxt = '1;
            ovf_nxt = 1'b1;
          end else begin
            acc_nxt = prod[VALUE_WIDTH-1:0];
          end
        end
        adv = 1'b1;
      end
    end

    // Saturate the position count
    pos_nxt = (adv && pos_r != '1) ? pos_r + COUNT_WIDTH'(1) : pos_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SPACE;
      acc_r   <= '0;
      neg_r   <= 1'b0;
      ab_r    <= BASE_AUTO;
      pos_r   <= '0;
      ovf_r   <= 1'b0;
    end else if (step_go) begin
      if (item.is_last) begin
        phase_r <= PH_SPACE;
        acc_r   <= '0;
        neg_r   <= 1'b0;
        ab_r    <= BASE_AUTO;
        pos_r   <= '0;
        ovf_r   <= 1'b0;
      end else begin
        phase_r <= phase_nxt;
        acc_r   <= acc_nxt;
        neg_r   <= neg_nxt;
        ab_r    <= ab_nxt;
        pos_r   <= pos_nxt;
        ovf_r   <= ovf_nxt;
      end
    end
  end

  assign raw.phase = phase_nxt;
  assign raw.acc   = acc_nxt;
  assign raw.neg   = neg_nxt;
  assign raw.ovf   = ovf_nxt;
  assign raw.sgn   = sgn_r;
  assign raw.pos   = pos_nxt;

endmodule

@@ rtl/s2i_finish.sv @@
module s2i_finish
  import s2i_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      raw_push,
  input  s2i_raw_t  raw,
  output logic      raw_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  localparam logic [VALUE_WIDTH-1:0] SMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic [VALUE_WIDTH-1:0] SMIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  s2i_raw_t  raw_r;
  logic      raw_vld_r, raw_vld_nxt;
  out_item_t out_r, fin;
  logic      out_vld_r, out_vld_nxt;
  logic      fin_take;

  assign fin_take    = !out_vld_r || out_ready;
  assign raw_ready   = !raw_vld_r || fin_take;
  assign raw_vld_nxt = raw_ready ? raw_push : raw_vld_r;
  assign out_vld_nxt = fin_take ? raw_vld_r : out_vld_r;

  always_comb begin
    fin.value_bits     = '0;
    fin.status_code    = ST_NOINT;
    fin.consumed_count = raw_r.pos;
    unique case (raw_r.phase)
      PH_BADBASE: begin
        fin.status_code    = ST_BADBASE;
        fin.consumed_count = '0;
      end
      PH_ZERO, PH_DIGITS, PH_VALUE: begin
        fin.status_code = raw_r.ovf ? ST_RANGE : ST_OK;
        if (raw_r.sgn) begin
          if (raw_r.acc[VALUE_WIDTH-1]) begin
            // Exact signed minimum is representable
            if (raw_r.neg && raw_r.acc == SMIN) begin
              fin.value_bits = SMIN;
            end else begin
              fin.value_bits  = raw_r.neg ? SMIN : SMAX;
              fin.status_code = ST_RANGE;
            end
          end else begin
            fin.value_bits = raw_r.neg ? VALUE_WIDTH'(0) - raw_r.acc : raw_r.acc;
          end
        end else begin
          fin.value_bits = raw_r.acc;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      raw_vld_r <= raw_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (raw_push && raw_ready) begin
      raw_r <= raw;
    end
    if (raw_vld_r && fin_take) begin
      out_r <= fin;
    end
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_r;

endmodule

@@ rtl/string_to_integer_parser_top.sv @@
// channel | ports                               | accepted when
// input   | in_valid, in_ready, in_item         | in_valid && in_ready
// result  | out_valid, out_ready, out_item      | out_valid && out_ready
// config  | cfg_we, cfg_index, cfg_wdata        | cfg_we
//
// One character a cycle unless a last character waits on a full snapshot; each
// passes an input register and one parse step (one 64 x 6 multiply-add on the
// accumulator); a last one then passes state snapshot and result register.
// Reset (rst_n low, synchronous) empties all stages and returns the parser to
// whitespace skip; base 0 and signed mode are restored.
// A stalled result holds; characters other than the last keep flowing under stall.
module string_to_integer_parser_top
  import s2i_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  in_item_t                   in_item,
  output logic                       out_valid,
  input  logic                       out_ready,
  output out_item_t                  out_item,
  input  logic                       cfg_we,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_wdata
);

  logic     item_vld;
  in_item_t item;
  logic     step_go;
  logic     raw_ready;
  logic     raw_push;
  s2i_raw_t raw;

  s2i_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .step_go  (step_go),
    .item_vld (item_vld),
    .item     (item)
  );

  s2i_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .item_vld  (item_vld),
    .item      (item),
    .raw_ready (raw_ready),
    .step_go   (step_go),
    .raw_push  (raw_push),
    .raw       (raw)
  );

  s2i_finish u_finish (
    .clk       (clk),
    .rst_n     (rst_n),
    .raw_push  (raw_push),
    .raw       (raw),
    .raw_ready (raw_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

@@ rtl/s2i_checker.sv @@
module s2i_checker
  import s2i_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_item
);

  // Hold a stalled transaction
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  // A free result side must never stall the input
  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled with result side free");

  a_badbase_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status_code == ST_BADBASE |->
      out_item.value_bits == '0 && out_item.consumed_count == '0)
    else $error("bad base result carries value or count");

  a_noint_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status_code == ST_NOINT |-> out_item.value_bits == '0)
    else $error("no-integer result carries a value");

endmodule

bind string_to_integer_parser_top s2i_checker u_s2i_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

@@ dv/string_to_integer_parser_top_tb.sv @@
module string_to_integer_parser_top_tb;
  import s2i_pkg::*;

  localparam logic [VALUE_WIDTH-1:0] ALL_ONES   = {VALUE_WIDTH{1'b1}};
  localparam logic [VALUE_WIDTH-1:0] SIGNED_MAX = ALL_ONES >> 1;
  localparam logic [VALUE_WIDTH-1:0] SIGNED_MIN = ~SIGNED_MAX;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX  = {COUNT_WIDTH{1'b1}};

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  in_item_t                   in_item = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  out_item_t                  out_item;
  logic                       cfg_we = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = CFG_NUMBER_BASE;
  logic [CFG_DATA_WIDTH-1:0]  cfg_wdata = '0;

  string_to_integer_parser_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Register copies
  logic [BASE_WIDTH-1:0]  base_reg = BASE_AUTO;
  logic                   signed_reg = 1'b1;

  // Parser state as the block should hold it
  phase_t                 phase = PH_SPACE;
  logic [VALUE_WIDTH-1:0] acc = '0;
  logic                   neg = 1'b0;
  logic [BASE_WIDTH-1:0]  base_now = BASE_AUTO;
  logic [COUNT_WIDTH-1:0] pos = '0;
  logic                   ovf = 1'b0;

  in_item_t               char_stream[$];
  out_item_t              expected_parses[$];
  logic [7:0]             draft[$];
  int                     mismatches = 0;
  int                     cycle_count = 0;
  logic                   calm;

  assign calm = (cycle_count >= 300) && (cycle_count < 700);

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  function automatic logic is_blank(input logic [7:0] c);
    return c == 8'h20 || (c > 8'h08 && c < 8'h0e);
  endfunction

  function automatic logic [BASE_WIDTH-1:0] char_digit(input logic [7:0] c);
    logic [7:0] u;
    u = c & 8'hDF;
    if (c >= CH_ZERO && c <= CH_NINE) return BASE_WIDTH'(c - CH_ZERO);
    if (u >= CH_UPPER_A && u <= CH_UPPER_Z) return BASE_WIDTH'(u - CH_UPPER_A + 8'd10);
    return DIGIT_NONE;
  endfunction

  function automatic void bump();
    if (pos != COUNT_MAX) pos = pos + 1'b1;
  endfunction

  function automatic void next_digit(input logic [7:0] c);
    logic [BASE_WIDTH-1:0] d;
    d = char_digit(c);
    if (d >= base_now || base_now < BASE_TWO) begin
      phase = PH_VALUE;
      return;
    end
    if (!ovf) begin
      if (acc > (ALL_ONES - d) / base_now) begin
        acc = ALL_ONES;
        ovf = 1'b1;
      end else begin
        acc = acc * base_now + d;
      end
    end
    bump();
  endfunction

  function automatic void lead_digit(input logic [7:0] c);
    logic [BASE_WIDTH-1:0] d;
    d = char_digit(c);
    if (d >= base_now || base_now < BASE_TWO) begin
      phase = PH_NOINT;
      return;
    end
    acc = VALUE_WIDTH'(d);
    phase = PH_DIGITS;
    bump();
  endfunction

  function automatic void begin_number(input logic [7:0] c);
    if (base_now == BASE_AUTO) begin
      if (c == CH_ZERO) begin
        acc = '0;
        phase = PH_ZERO;
        bump();
        return;
      end
      base_now = BASE_DEC;
    end
    lead_digit(c);
  endfunction

  // Advance the parse by one character; a last character yields one result
  function automatic void parse_char(input in_item_t it);
    logic [7:0] c;
    out_item_t  res;
    c = it.char_code;
    if (phase == PH_SPACE && pos == '0) begin
      base_now = base_reg;
      if (base_now == BASE_ONE || base_now > MAX_BASE) phase = PH_BADBASE;
    end
    case (phase)
      PH_SPACE: begin
        if (is_blank(c)) begin
          bump();
        end else if (!it.is_last && (c == CH_PLUS || (c == CH_MINUS && signed_reg))) begin
          neg = (c == CH_MINUS);
          phase = PH_FIRST;
          bump();
        end else begin
          begin_number(c);
        end
      end
      PH_FIRST: begin_number(c);
      PH_ZERO: begin
        if (c == CH_LOWER_X) begin
          base_now = BASE_HEX;
          phase = PH_HEXFIRST;
          bump();
        end else begin
          base_now = BASE_OCT;
          phase = PH_DIGITS;
          next_digit(c);
        end
      end
      PH_HEXFIRST: lead_digit(c);
      PH_DIGITS: next_digit(c);
      default: ;
    endcase
    if (!it.is_last) return;

    res = '0;
    res.consumed_count = pos;
    case (phase)
      PH_BADBASE: begin
        res.status_code = ST_BADBASE;
        res.consumed_count = '0;
      end
      PH_ZERO, PH_DIGITS, PH_VALUE: begin
        res.status_code = ovf ? ST_RANGE : ST_OK;
        if (!signed_reg) begin
          res.value_bits = acc;
        end else if (acc <= SIGNED_MAX) begin
          res.value_bits = neg ? -acc : acc;
        end else if (neg && acc == SIGNED_MIN) begin
          res.value_bits = SIGNED_MIN;
        end else begin
          res.value_bits = neg ? SIGNED_MIN : SIGNED_MAX;
          res.status_code = ST_RANGE;
        end
      end
      default: res.status_code = ST_NOINT;
    endcase
    expected_parses.push_back(res);

    phase = PH_SPACE;
    acc = '0;
    neg = 1'b0;
    base_now = BASE_AUTO;
    pos = '0;
    ovf = 1'b0;
  endfunction

  // Driver: hold the payload until the transaction completes
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) parse_char(in_item);
      if (!in_valid || in_ready) begin
        if (char_stream.size() != 0 && (calm || $urandom_range(0, 99) >= 8)) begin
          in_valid <= 1'b1;
          in_item <= char_stream.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_parses.size() == 0) begin
          $error("unexpected result: value_bits %h status_code %0d consumed_count %0d",
                 out_item.value_bits, out_item.status_code, out_item.consumed_count);
          mismatches++;
        end else begin
          want = expected_parses.pop_front();
          if (out_item.value_bits !== want.value_bits) begin
            $error("value_bits: expected %h, got %h", want.value_bits, out_item.value_bits);
            mismatches++;
          end
          if (out_item.status_code !== want.status_code) begin
            $error("status_code: expected %0d, got %0d", want.status_code,
                   out_item.status_code);
            mismatches++;
          end
          if (out_item.consumed_count !== want.consumed_count) begin
            $error("consumed_count: expected %0d, got %0d", want.consumed_count,
                   out_item.consumed_count);
            mismatches++;
          end
        end
      end
      out_ready <= calm || ($urandom_range(0, 99) >= 8);
    end
  end

  function automatic void push_char(input logic [7:0] c, input logic last);
    in_item_t it;
    it.char_code = c;
    it.is_last = last;
    char_stream.push_back(it);
  endfunction

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i], i == s.len() - 1);
  endfunction

  function automatic logic [7:0] odd_char();
    case ($urandom_range(0, 9))
      0: return CH_SPACE;
      1: return CH_PLUS;
      2: return CH_MINUS;
      3: return CH_ZERO;
      4: return CH_LOWER_X;
      5: return CH_NINE;
      6: return CH_UPPER_Z;
      7: return 8'hFF;
      8: return 8'h00;
      default: return CH_LOWER_Z;
    endcase
  endfunction

  // Build one string around the current base setting, queue it, return its length
  function automatic int make_string();
    int          radix;
    int          n;
    int          d;
    logic [71:0] v;
    logic [7:0]  digs[$];
    draft.delete();
    if ($urandom_range(0, 99) < 15) begin
      n = $urandom_range(1, 6);
      repeat (n) draft.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : odd_char());
    end else begin
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 2))
          draft.push_back($urandom_range(0, 5) == 0 ? CH_SPACE : 8'($urandom_range(9, 13)));
      end
      case ($urandom_range(0, 9))
        0, 1, 2: draft.push_back(CH_MINUS);
        3, 4:    draft.push_back(CH_PLUS);
        default: ;
      endcase
      radix = 10;
      if (base_reg >= BASE_TWO && base_reg <= MAX_BASE) begin
        radix = base_reg;
        if (radix == 16 && $urandom_range(0, 4) == 0) begin
          draft.push_back(CH_ZERO);
          draft.push_back(CH_LOWER_X);
        end
      end else if (base_reg == BASE_AUTO) begin
        case ($urandom_range(0, 2))
          0: begin
            radix = 8;
            draft.push_back(CH_ZERO);
          end
          1: radix = 10;
          default: begin
            radix = 16;
            draft.push_back(CH_ZERO);
            draft.push_back(CH_LOWER_X);
          end
        endcase
      end
      n = $urandom_range(0, 99);
      if (n < 70) begin
        v = $urandom_range(0, 999);
      end else if (n < 85) begin
        v = {$urandom, $urandom} >> $urandom_range(0, 63);
      end else begin
        // near the signed and unsigned limits
        v = ($urandom_range(0, 1) ? 72'h1_0000_0000_0000_0000 : 72'h0_8000_0000_0000_0000)
            - 72'd2 + $urandom_range(0, 4);
      end
      do begin
        d = int'(v % radix);
        if (d < 10) digs.push_front(CH_ZERO + 8'(d));
        else digs.push_front(($urandom_range(0, 1) ? CH_LOWER_A : CH_UPPER_A) + 8'(d - 10));
        v = v / radix;
      end while (v != 0);
      foreach (digs[i]) draft.push_back(digs[i]);
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 2)) draft.push_back(8'($urandom_range(0, 255)));
      end
    end
    foreach (draft[i]) push_char(draft[i], i == draft.size() - 1);
    return draft.size();
  endfunction

  task automatic random_strings(input int budget);
    int sent;
    sent = 0;
    while (sent < budget) sent += make_string();
  endtask

  task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                           input logic [CFG_DATA_WIDTH-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    if (idx == CFG_NUMBER_BASE) base_reg = data;
    else signed_reg = data[0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(input logic [BASE_WIDTH-1:0] b, input logic s);
    write_reg(CFG_NUMBER_BASE, b);
    write_reg(CFG_SIGNED_MODE, CFG_DATA_WIDTH'(s));
    @(negedge clk);
  endtask

  // Wait for the stream to drain, then let the pipeline settle
  task automatic settle();
    while (char_stream.size() != 0 || in_valid || expected_parses.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // detect mode, signed
    push_text("0");
    push_text("-");
    push_text("\015");
    push_text("08");
    push_text("0x");
    push_text("0xg");
    push_text("+7z");
    push_char(8'hFF, 1'b0);
    push_char(8'h00, 1'b1);
    push_text("\t-0X");
    random_strings(60);
    settle();

    configure(6'd10, 1'b0);
    push_text("-5");
    random_strings(80);
    settle();

    configure(6'd16, 1'b1);
    random_strings(80);
    settle();

    configure(6'd2, 1'b1);
    random_strings(80);
    settle();

    configure(6'd36, 1'b0);
    random_strings(80);
    settle();

    configure(6'd1, 1'b1);
    push_text("5");
    random_strings(20);
    settle();

    configure(6'd63, 1'b0);
    random_strings(20);
    settle();

    configure(6'd37, 1'b1);
    random_strings(15);
    settle();

    configure(6'd0, 1'b0);
    random_strings(80);
    settle();

    configure(6'd8, 1'b1);
    random_strings(70);
    settle();

    configure(6'd0, 1'b1);
    random_strings(80);
    settle();

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("status: fail");
    $finish;
  end

endmodule

@@ string_to_integer_parser_top.f @@
rtl/s2i_pkg.sv
rtl/s2i_in_reg.sv
rtl/s2i_parse.sv
rtl/s2i_finish.sv
rtl/string_to_integer_parser_top.sv
rtl/s2i_checker.sv
dv/string_to_integer_parser_top_tb.sv
